// ===== rtl/dcd_pkg.sv =====
// Shared types and constants for the datagram capsule deframer.
package dcd_pkg;

    localparam int VARINT_W = 62;
    localparam int CFG_IDX_W = 2;

    localparam logic [5:0] VARINT_LOW_MASK = 6'h3f;

    localparam logic [CFG_IDX_W-1:0] CFG_DATAGRAM_TYPE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTEXT_ID    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH    = 2'd2;

    localparam logic [VARINT_W-1:0] MAX_LENGTH_RESET = 62'd65536;

    localparam logic [1:0] RK_PAYLOAD = 2'd0;
    localparam logic [1:0] RK_EMPTY   = 2'd1;
    localparam logic [1:0] RK_ERROR   = 2'd2;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_TYPE      = 3'd1;
    localparam logic [2:0] ERR_LENGTH    = 3'd2;
    localparam logic [2:0] ERR_CONTEXT   = 3'd3;
    localparam logic [2:0] ERR_TRUNCATED = 3'd4;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } dcd_item_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] result_kind;
        logic [7:0] payload_byte;
        logic       last_of_datagram;
        logic [2:0] error_code;
    } dcd_result_t;

endpackage

// ===== rtl/datagram_capsule_deframer_core.sv =====
// Each item moves from the input register through the parser; results go into the output register.
// Throughput: one item per cycle; the input register, parser and output register
// each pass one item a cycle, stalled only by m_tready.
// Reset (aresetn low, synchronous): parser returns to the capsule type, the failed
// flag clears, both stages empty, config registers take their reset values.
module datagram_capsule_deframer_core
    import dcd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [VARINT_W-1:0]  cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] data_byte
    input  logic                 s_tuser,   // [0] kind
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,   // [7:0] payload_byte, [10:8] error_code
    output logic [1:0]           m_tuser,   // [1:0] result_kind
    output logic                 m_tlast
);

    dcd_item_t   in_item;
    dcd_item_t   item;
    logic        item_valid;
    logic        advance;
    logic        out_free;
    dcd_result_t res;
    dcd_result_t out_res;

    assign in_item.kind      = s_tuser;
    assign in_item.data_byte = s_tdata;
    assign advance           = item_valid && out_free;

    dcd_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    dcd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .advance   (advance),
        .item      (item),
        .res       (res)
    );

    dcd_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .res       (res),
        .out_free  (out_free),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {5'd0, out_res.error_code, out_res.payload_byte};
    assign m_tuser = out_res.result_kind;
    assign m_tlast = out_res.last_of_datagram;

endmodule

// ===== rtl/dcd_in_stage.sv =====
// Input register stage holding one accepted item.
module dcd_in_stage
    import dcd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  dcd_item_t in_item,
    input  logic      advance,
    output logic      item_valid,
    output dcd_item_t item
);

    logic      valid_reg;
    logic      valid_next;
    dcd_item_t item_reg;

    assign in_ready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (in_valid && in_ready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (in_valid && in_ready) begin
            item_reg <= in_item;
        end
    end

endmodule

// ===== rtl/dcd_parser.sv =====
// Capsule header parser: varint decode, checks, payload count, config registers.
module dcd_parser
    import dcd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [VARINT_W-1:0]  cfg_wdata,
    input  logic                 advance,
    input  dcd_item_t            item,
    output dcd_result_t          res
);

    typedef enum logic [1:0] {
        PH_TYPE,
        PH_LENGTH,
        PH_CONTEXT,
        PH_PAYLOAD
    } phase_t;

    logic [VARINT_W-1:0] dtype_reg;
    logic [VARINT_W-1:0] ctx_reg;
    logic [VARINT_W-1:0] maxlen_reg;

    phase_t              phase_reg, phase_next;
    logic [VARINT_W-1:0] value_reg, value_next;
    logic [2:0]          left_reg, left_next;
    logic [3:0]          size_reg, size_next;
    logic [VARINT_W-1:0] caplen_reg, caplen_next;
    logic [VARINT_W-1:0] payleft_reg, payleft_next;
    logic                failed_reg, failed_next;

    logic                done;

    always_comb begin
        phase_next   = phase_reg;
        value_next   = value_reg;
        left_next    = left_reg;
        size_next    = size_reg;
        caplen_next  = caplen_reg;
        payleft_next = payleft_reg;
        failed_next  = failed_reg;
        done         = 1'b0;
        res          = '0;

        if (failed_reg) begin
            res = '0;
        end else if (item.kind) begin
            if (phase_reg != PH_TYPE || left_reg != 3'd0) begin
                failed_next     = 1'b1;
                res.valid       = 1'b1;
                res.result_kind = RK_ERROR;
                res.error_code  = ERR_TRUNCATED;
            end
        end else if (phase_reg == PH_PAYLOAD) begin
            payleft_next         = payleft_reg - 62'd1;
            res.valid            = 1'b1;
            res.result_kind      = RK_PAYLOAD;
            res.payload_byte     = item.data_byte;
            res.last_of_datagram = (payleft_reg == 62'd1);
            if (payleft_reg == 62'd1) begin
                phase_next = PH_TYPE;
            end
        end else begin
            if (left_reg == 3'd0) begin
                size_next  = 4'd1 << item.data_byte[7:6];
                value_next = {56'd0, item.data_byte[5:0] & VARINT_LOW_MASK};
                left_next  = 3'((4'd1 << item.data_byte[7:6]) - 4'd1);
            end else begin
                value_next = {value_reg[VARINT_W-9:0], item.data_byte};
                left_next  = left_reg - 3'd1;
            end
            done = (left_next == 3'd0);

            if (done) begin
                case (phase_reg)
                    PH_TYPE: begin
                        if (value_next != dtype_reg) begin
                            failed_next     = 1'b1;
                            res.valid       = 1'b1;
                            res.result_kind = RK_ERROR;
                            res.error_code  = ERR_TYPE;
                        end else begin
                            phase_next = PH_LENGTH;
                        end
                    end
                    PH_LENGTH: begin
                        if (value_next > maxlen_reg) begin
                            failed_next     = 1'b1;
                            res.valid       = 1'b1;
                            res.result_kind = RK_ERROR;
                            res.error_code  = ERR_LENGTH;
                        end else begin
                            caplen_next = value_next;
                            phase_next  = PH_CONTEXT;
                        end
                    end
                    PH_CONTEXT: begin
                        payleft_next = caplen_reg - {58'd0, size_next};
                        if (value_next != ctx_reg || caplen_reg < {58'd0, size_next}) begin
                            failed_next     = 1'b1;
                            res.valid       = 1'b1;
                            res.result_kind = RK_ERROR;
                            res.error_code  = ERR_CONTEXT;
                        end else if (caplen_reg == {58'd0, size_next}) begin
                            phase_next      = PH_TYPE;
                            res.valid       = 1'b1;
                            res.result_kind = RK_EMPTY;
                        end else begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                    default: begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dtype_reg   <= '0;
            ctx_reg     <= '0;
            maxlen_reg  <= MAX_LENGTH_RESET;
            phase_reg   <= PH_TYPE;
            value_reg   <= '0;
            left_reg    <= 3'd0;
            size_reg    <= 4'd0;
            caplen_reg  <= '0;
            payleft_reg <= '0;
            failed_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_DATAGRAM_TYPE: dtype_reg  <= cfg_wdata;
                    CFG_CONTEXT_ID:    ctx_reg    <= cfg_wdata;
                    CFG_MAX_LENGTH:    maxlen_reg <= cfg_wdata;
                    default: begin
                        dtype_reg <= dtype_reg;
                    end
                endcase
            end
            if (advance) begin
                phase_reg   <= phase_next;
                value_reg   <= value_next;
                left_reg    <= left_next;
                size_reg    <= size_next;
                caplen_reg  <= caplen_next;
                payleft_reg <= payleft_next;
                failed_reg  <= failed_next;
            end
        end
    end

    a_error_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && res.valid && res.result_kind == RK_ERROR |=> failed_reg)
        else $error("error result did not set the failed flag");

    a_failed_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        failed_reg |-> !res.valid)
        else $error("result produced after failure");

    a_payload_count: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PAYLOAD |-> payleft_reg != 62'd0 && left_reg == 3'd0)
        else $error("payload phase with empty count or open varint");

    a_failed_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        failed_reg |=> $stable(phase_reg) && $stable(left_reg) && failed_reg)
        else $error("state changed after failure");

endmodule

// ===== rtl/dcd_out_stage.sv =====
// Output register stage holding one result item.
module dcd_out_stage
    import dcd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        advance,
    input  dcd_result_t res,
    output logic        out_free,
    output logic        out_valid,
    input  logic        out_ready,
    output dcd_result_t out_res
);

    logic        valid_reg;
    logic        valid_next;
    logic        load;
    dcd_result_t res_reg;

    assign load      = advance && res.valid;
    assign out_free  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (load) begin
            res_reg <= res;
        end
    end

endmodule
